[hdl/unique_key_ordered_table_macros.svh]
// Assertion macros used by the ordered table top level
`ifndef UNIQUE_KEY_ORDERED_TABLE_MACROS_SVH
`define UNIQUE_KEY_ORDERED_TABLE_MACROS_SVH

// Property must hold on every rising clock edge out of reset
`define UKOT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen out of reset
`define UKOT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[hdl/ukot_pkg.sv]
// Types and codes for the unique-key ordered table
`timescale 1ns / 1ps

package ukot_pkg;

    localparam int unsigned KEY_W  = 64;
    localparam int unsigned ADDR_W = 64;

    typedef enum logic [1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_REMOVE   = 2'd1,
        FUNC_LOOKUP   = 2'd2,
        FUNC_TRAVERSE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_DUP  = 2'd1,
        STAT_MISS = 2'd2,
        STAT_FULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_REM  = 2'd2,
        CELL_ROT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic     cmp;
        t_cell_op op;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ACT  = 3'b010,
        ST_TRAV = 3'b100
    } t_state;

endpackage

[hdl/ukot_cell.sv]
// One table slot: key/addr storage, key compare and neighbor shift
`timescale 1ns / 1ps

module ukot_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ukot_pkg::t_cell_ctl           i_ctl,
    input  logic [ukot_pkg::KEY_W-1:0]    i_cmp_key,
    input  logic [ukot_pkg::KEY_W-1:0]    i_ins_key,
    input  logic [ukot_pkg::ADDR_W-1:0]   i_ins_addr,
    input  logic [ukot_pkg::KEY_W-1:0]    i_next_key,
    input  logic [ukot_pkg::ADDR_W-1:0]   i_next_addr,
    input  logic                          i_next_valid,
    input  logic                          i_prev_valid,
    input  logic [ukot_pkg::KEY_W-1:0]    i_head_key,
    input  logic [ukot_pkg::ADDR_W-1:0]   i_head_addr,
    input  logic                          i_shift,
    output logic [ukot_pkg::KEY_W-1:0]    o_key,
    output logic [ukot_pkg::ADDR_W-1:0]   o_addr,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic                          o_shift
);

    logic [ukot_pkg::KEY_W-1:0]  r_key;
    logic [ukot_pkg::ADDR_W-1:0] r_addr;
    logic                        r_valid;
    logic                        r_hit;
    logic                        w_shift;
    logic                        w_ins;

    // slot shifts down once it or any older slot holds the removed key
    assign w_shift = i_shift | r_hit;
    assign w_ins   = !r_valid && i_prev_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_hit <= r_valid && (r_key == i_cmp_key);
            end
            unique case (i_ctl.op)
                ukot_pkg::CELL_INS: begin
                    if (w_ins) r_valid <= 1'b1;
                end
                ukot_pkg::CELL_REM: begin
                    if (w_shift) r_valid <= i_next_valid;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            ukot_pkg::CELL_INS: begin
                if (w_ins) begin
                    r_key  <= i_ins_key;
                    r_addr <= i_ins_addr;
                end
            end
            ukot_pkg::CELL_REM: begin
                if (w_shift) begin
                    r_key  <= i_next_key;
                    r_addr <= i_next_addr;
                end
            end
            ukot_pkg::CELL_ROT: begin
                if (r_valid) begin
                    r_key  <= i_next_valid ? i_next_key  : i_head_key;
                    r_addr <= i_next_valid ? i_next_addr : i_head_addr;
                end
            end
            default: ;
        endcase
    end

    assign o_key   = r_key;
    assign o_addr  = r_addr;
    assign o_valid = r_valid;
    assign o_hit   = r_hit;
    assign o_shift = w_shift;

endmodule

[hdl/unique_key_ordered_table.sv]
// Top level of the unique-key ordered table: cell chain and command sequencer
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  command | in  | start & !busy      | i_func, i_key, i_addr
//  result  | out | o_strobe, no stall | o_status, o_key_out, o_addr_out, o_last
//
// Insert, remove and lookup: the accept edge registers the key compare in every cell,
// then the ACT state updates the chain and the result register.
// Traverse: after the ACT state the chain rotates one slot per cycle and the head
// cell is emitted each cycle, once per held entry. An empty traverse ends after ACT.
// Reset clears all valid and hit bits, the count and the sequencer; nothing else is cleared.
// The result is registered as the command finishes and is presented when busy is already low.
`timescale 1ns / 1ps

`include "unique_key_ordered_table_macros.svh"

module unique_key_ordered_table #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_func,
    input  logic signed [ukot_pkg::KEY_W-1:0]    i_key,
    input  logic [ukot_pkg::ADDR_W-1:0]          i_addr,
    output logic                                 o_strobe,
    output logic [1:0]                           o_status,
    output logic signed [ukot_pkg::KEY_W-1:0]    o_key_out,
    output logic [ukot_pkg::ADDR_W-1:0]          o_addr_out,
    output logic                                 o_last
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ukot_pkg::t_state                r_state, n_state;
    ukot_pkg::t_func                 r_func;
    logic [ukot_pkg::KEY_W-1:0]      r_key;
    logic [ukot_pkg::ADDR_W-1:0]     r_addr;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [CNT_W-1:0]                r_left, n_left;

    logic                            r_strobe, n_strobe;
    ukot_pkg::t_status               r_status, n_status;
    logic [ukot_pkg::KEY_W-1:0]      r_key_out, n_key_out;
    logic [ukot_pkg::ADDR_W-1:0]     r_addr_out, n_addr_out;
    logic                            r_last, n_last;

    ukot_pkg::t_cell_ctl             w_ctl;
    logic                            w_accept;

    logic [ukot_pkg::KEY_W-1:0]      w_key   [DEPTH+1];
    logic [ukot_pkg::ADDR_W-1:0]     w_addr  [DEPTH+1];
    logic [DEPTH:0]                  w_valid;
    logic [DEPTH:0]                  w_shift;
    logic [DEPTH-1:0]                w_hit;
    logic                            w_any_hit;
    logic [ukot_pkg::KEY_W-1:0]      w_hit_key;
    logic [ukot_pkg::ADDR_W-1:0]     w_hit_addr;

    assign busy     = (r_state != ukot_pkg::ST_IDLE);
    assign w_accept = start && !busy;

    assign w_key[DEPTH]   = '0;
    assign w_addr[DEPTH]  = '0;
    assign w_valid[DEPTH] = 1'b0;
    assign w_shift[0]     = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ukot_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_cmp_key    (i_key),
            .i_ins_key    (r_key),
            .i_ins_addr   (r_addr),
            .i_next_key   (w_key[g+1]),
            .i_next_addr  (w_addr[g+1]),
            .i_next_valid (w_valid[g+1]),
            .i_prev_valid ((g == 0) ? 1'b1 : w_valid[(g == 0) ? 0 : g-1]),
            .i_head_key   (w_key[0]),
            .i_head_addr  (w_addr[0]),
            .i_shift      (w_shift[g]),
            .o_key        (w_key[g]),
            .o_addr       (w_addr[g]),
            .o_valid      (w_valid[g]),
            .o_hit        (w_hit[g]),
            .o_shift      (w_shift[g+1])
        );
    end

    assign w_any_hit = |w_hit;

    // at most one hit, so an OR of gated slots picks the match
    always_comb begin
        w_hit_key  = '0;
        w_hit_addr = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_hit_key  = w_hit_key  | (w_key[i]  & {ukot_pkg::KEY_W{w_hit[i]}});
            w_hit_addr = w_hit_addr | (w_addr[i] & {ukot_pkg::ADDR_W{w_hit[i]}});
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_left     = r_left;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_key_out  = r_key_out;
        n_addr_out = r_addr_out;
        n_last     = r_last;
        w_ctl.cmp  = w_accept;
        w_ctl.op   = ukot_pkg::CELL_HOLD;

        unique case (r_state)
            ukot_pkg::ST_IDLE: begin
                if (w_accept) n_state = ukot_pkg::ST_ACT;
            end
            ukot_pkg::ST_ACT: begin
                n_state    = ukot_pkg::ST_IDLE;
                n_strobe   = 1'b1;
                n_last     = 1'b1;
                n_key_out  = '0;
                n_addr_out = '0;
                unique case (r_func) inside
                    ukot_pkg::FUNC_INSERT: begin
                        if (w_any_hit) begin
                            n_status = ukot_pkg::STAT_DUP;
                        end else if (r_count == CNT_W'(DEPTH)) begin
                            n_status = ukot_pkg::STAT_FULL;
                        end else begin
                            n_status = ukot_pkg::STAT_OK;
                            w_ctl.op = ukot_pkg::CELL_INS;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end
                    ukot_pkg::FUNC_REMOVE, ukot_pkg::FUNC_LOOKUP: begin
                        if (w_any_hit) begin
                            n_status   = ukot_pkg::STAT_OK;
                            n_key_out  = w_hit_key;
                            n_addr_out = w_hit_addr;
                            if (r_func == ukot_pkg::FUNC_REMOVE) begin
                                w_ctl.op = ukot_pkg::CELL_REM;
                                n_count  = r_count - CNT_W'(1);
                            end
                        end else begin
                            n_status = ukot_pkg::STAT_MISS;
                        end
                    end
                    default: begin
                        if (r_count == '0) begin
                            n_status = ukot_pkg::STAT_MISS;
                        end else begin
                            n_strobe = 1'b0;
                            n_left   = r_count;
                            n_state  = ukot_pkg::ST_TRAV;
                        end
                    end
                endcase
            end
            ukot_pkg::ST_TRAV: begin
                w_ctl.op   = ukot_pkg::CELL_ROT;
                n_strobe   = 1'b1;
                n_status   = ukot_pkg::STAT_OK;
                n_key_out  = w_key[0];
                n_addr_out = w_addr[0];
                n_last     = (r_left == CNT_W'(1));
                n_left     = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) n_state = ukot_pkg::ST_IDLE;
            end
            default: n_state = ukot_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ukot_pkg::ST_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= ukot_pkg::t_func'(i_func);
            r_key  <= i_key;
            r_addr <= i_addr;
        end
        r_status   <= n_status;
        r_key_out  <= n_key_out;
        r_addr_out <= n_addr_out;
        r_last     <= n_last;
    end

    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_key_out  = r_key_out;
    assign o_addr_out = r_addr_out;
    assign o_last     = r_last;

    `UKOT_ASSERT(a_packed, i_clk, i_rst_n, ((w_valid & (w_valid + (DEPTH+1)'(1))) == '0), "valid slots not packed")
    `UKOT_ASSERT(a_count, i_clk, i_rst_n, ($countones(w_valid) == int'(r_count)), "count mismatch")
    `UKOT_ASSERT(a_hit_1h, i_clk, i_rst_n, $onehot0(w_hit), "multiple key matches")
    `UKOT_ASSERT(a_single_res, i_clk, i_rst_n, ((r_state == ukot_pkg::ST_ACT) && (r_func != ukot_pkg::FUNC_TRAVERSE) |=> o_strobe && o_last), "missing result")

endmodule
